// ===== hdl/bfr_pkg.sv =====
// Shared types and constants for the 5x5 replicate-border box filter.
package bfr_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 4096;
   localparam int HALF_WINDOW = 2;
   localparam int SPAN        = 2 * HALF_WINDOW + 1;
   localparam int LROWS       = 2 * HALF_WINDOW;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int NCHAN       = 3;
   localparam int NSLOT       = HALF_WINDOW + 1;
   localparam int SUM_W       = 13;
   localparam int RECIP       = 5243;
   localparam int RECIP_SHIFT = 17;
   localparam int OQ_DEPTH    = 8;
   localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_COLOR_MODE   = 2'd2;

   typedef logic [23:0] pix_type;
   typedef logic [SPAN-1:0][23:0] pix_col_type;
   typedef logic [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic       action;
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
   } req_type;

   typedef struct packed {
      logic [7:0] mean0;
      logic [7:0] mean1;
      logic [7:0] mean2;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic       fresh;
      logic [1:0] s_lo;
   } lane_ctl_type;

   typedef struct packed {
      logic [NSLOT-1:0][23:0] means;
      logic [1:0]             n;
      logic                   fe;
   } grp_type;

endpackage

// ===== hdl/box_filter_5x5_replicate_core.sv =====
// Top level of the streaming 5x5 box filter with replicated borders.
// One input item is taken per clock cycle while req_stall is low. Each pixel passes a
// line-store read (stage 1), column build and window sums in three channel lanes (stage 2),
// a reciprocal multiply (stage 3) and a result queue with an output register. The last pixel
// of a row gives up to three results; the output sends one per cycle from an eight-group
// queue while rsp_stall is low, and the input stalls while that queue and the stages ahead
// of it could fill it. The line store needs no clearing pass after reset.
module box_filter_5x5_replicate_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfr_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [12:0]      csr_data
);
   import bfr_pkg::*;

   logic [11:0]        width_ff;
   logic [12:0]        height_ff;
   logic               color_ff;
   logic [12:0]        row_ff;
   logic [11:0]        col_ff;
   logic               drain_ff;

   logic               accept, take, last, deep;
   logic [ADDR_W-1:0]  wm1, col;
   logic [12:0]        h, r;
   logic [1:0]         s_lo, n;
   logic               fe;

   logic               vb_ff, vc_ff, vd_ff;
   lane_ctl_type       ctlb_ff;
   logic [1:0]         nb_ff, nc_ff, nd_ff;
   logic               feb_ff, fec_ff, fed_ff;

   pix_col_type                   column;
   logic [SPAN-1:0][7:0]          samples [NCHAN];
   logic [NSLOT-1:0][7:0]         means [NCHAN];
   logic [OQ_PTR_W:0]             q_count;
   grp_type                       grp;
   logic                          push;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (q_count + (OQ_PTR_W+1)'(vb_ff) + (OQ_PTR_W+1)'(vc_ff)
                       + (OQ_PTR_W+1)'(vd_ff)) >= (OQ_PTR_W+1)'(OQ_DEPTH);

   always_comb begin
      if (width_ff == '0) begin
         wm1 = '0;
      end else if (width_ff > 12'(MAX_WIDTH)) begin
         wm1 = ADDR_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = ADDR_W'(width_ff - 12'd1);
      end
      if (height_ff == '0) begin
         h = 13'd1;
      end else if (height_ff > 13'(MAX_HEIGHT)) begin
         h = 13'(MAX_HEIGHT);
      end else begin
         h = height_ff;
      end
      take = accept && (req_data.action ? (row_ff >= h) : (row_ff < h));
      r    = req_data.action ? (h + 13'(drain_ff)) : row_ff;
      col  = (col_ff > 12'(wm1)) ? wm1 : col_ff[ADDR_W-1:0];
      last = (col == wm1);
      deep = (r >= 13'(HALF_WINDOW));
      fe   = last && (r == h + 13'd1);
      if (col >= ADDR_W'(2)) begin
         s_lo = 2'd0;
      end else if (col == ADDR_W'(1)) begin
         s_lo = 2'd1;
      end else begin
         s_lo = 2'd2;
      end
      if (!deep) begin
         n = 2'd0;
      end else if (last) begin
         n = 2'd3 - s_lo;
      end else begin
         n = (s_lo == 2'd0) ? 2'd1 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      ctlb_ff.fresh <= (col == '0);
      ctlb_ff.s_lo  <= s_lo;
      nb_ff  <= n;
      feb_ff <= fe;
      nc_ff  <= nb_ff;
      fec_ff <= feb_ff;
      nd_ff  <= nc_ff;
      fed_ff <= fec_ff;
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
         color_ff  <= 1'b0;
         row_ff    <= '0;
         col_ff    <= '0;
         drain_ff  <= 1'b0;
         vb_ff     <= 1'b0;
         vc_ff     <= 1'b0;
         vd_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_data[11:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_data;
               CSR_COLOR_MODE:   color_ff  <= csr_data[0];
               default: ;
            endcase
         end
         if (take) begin
            if (last) begin
               col_ff <= '0;
               if (!req_data.action) begin
                  row_ff <= row_ff + 13'd1;
               end else if (drain_ff) begin
                  row_ff   <= '0;
                  drain_ff <= 1'b0;
               end else begin
                  drain_ff <= 1'b1;
               end
            end else begin
               col_ff <= 12'(col) + 12'd1;
            end
         end
         vb_ff <= take;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   bfr_line u_line (
      .clock    (clock),
      .reset    (reset),
      .a_valid  (take),
      .a_addr   (col),
      .a_first  (r == '0),
      .a_drain  (req_data.action),
      .a_pixel  ({req_data.chan2, req_data.chan1, req_data.chan0}),
      .b_column (column)
   );

   for (genvar c = 0; c < NCHAN; c++) begin : g_lane
      for (genvar k = 0; k < SPAN; k++) begin : g_tap
         assign samples[c][k] = column[k][c*8 +: 8];
      end
      bfr_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .b_valid   (vb_ff),
         .b_ctl     (ctlb_ff),
         .b_samples (samples[c]),
         .d_means   (means[c])
      );
   end

   always_comb begin
      push   = vd_ff && (nd_ff != 2'd0);
      grp.n  = nd_ff;
      grp.fe = fed_ff;
      for (int i = 0; i < NSLOT; i++) begin
         grp.means[i] = {color_ff ? means[2][i] : 8'd0,
                         color_ff ? means[1][i] : 8'd0,
                         means[0][i]};
      end
   end

   bfr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_grp  (grp),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/bfr_line.sv =====
// Four-row line store with read-modify-write bypass; builds the vertical pixel column.
module bfr_line (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      a_valid,
   input  logic [bfr_pkg::ADDR_W-1:0] a_addr,
   input  logic                      a_first,
   input  logic                      a_drain,
   input  bfr_pkg::pix_type          a_pixel,
   output bfr_pkg::pix_col_type      b_column
);
   import bfr_pkg::*;

   logic [LROWS*24-1:0] mem [MAX_WIDTH];
   logic [LROWS*24-1:0] rd_ff;
   logic [LROWS*24-1:0] byp_data_ff;
   logic                byp_ff;
   logic                b_valid_ff;
   logic [ADDR_W-1:0]   b_addr_ff;
   logic                b_first_ff;
   logic                b_drain_ff;
   pix_type             b_pixel_ff;
   logic [LROWS*24-1:0] old_word;
   logic [LROWS*24-1:0] new_word;
   pix_type             cur;
   pix_col_type         col;

   always_comb begin
      old_word = byp_ff ? byp_data_ff : rd_ff;
      for (int k = 0; k < LROWS; k++) begin
         col[k] = old_word[k*24 +: 24];
      end
      cur = b_drain_ff ? col[LROWS-1] : b_pixel_ff;
      if (b_first_ff) begin
         for (int k = 0; k < LROWS; k++) begin
            col[k] = cur;
         end
      end
      col[LROWS] = cur;
      for (int k = 0; k < LROWS; k++) begin
         new_word[k*24 +: 24] = col[k+1];
      end
   end

   assign b_column = col;

   always_ff @(posedge clock) begin
      if (a_valid) begin
         rd_ff <= mem[a_addr];
      end
      if (b_valid_ff) begin
         mem[b_addr_ff] <= new_word;
      end
      byp_data_ff <= new_word;
      b_addr_ff   <= a_addr;
      b_first_ff  <= a_first;
      b_drain_ff  <= a_drain;
      b_pixel_ff  <= a_pixel;
      if (reset) begin
         b_valid_ff <= 1'b0;
         byp_ff     <= 1'b0;
      end else begin
         b_valid_ff <= a_valid;
         byp_ff     <= a_valid && b_valid_ff && (a_addr == b_addr_ff);
      end
   end

endmodule

// ===== hdl/bfr_lane.sv =====
// One channel lane: column sums of the window, 25-sample totals and divide by 25.
module bfr_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          b_valid,
   input  bfr_pkg::lane_ctl_type         b_ctl,
   input  logic [bfr_pkg::SPAN-1:0][7:0] b_samples,
   output logic [bfr_pkg::NSLOT-1:0][7:0] d_means
);
   import bfr_pkg::*;

   sum_type                 cs_ff [LROWS];
   sum_type                 vs;
   sum_type                 t0, t1, t2;
   sum_type                 slot_in [NSLOT];
   sum_type                 slot_ff [NSLOT];
   logic [2*SUM_W-1:0]      prod [NSLOT];
   logic [NSLOT-1:0][7:0]   means_ff;

   always_comb begin
      vs = '0;
      for (int k = 0; k < SPAN; k++) begin
         vs = vs + sum_type'(b_samples[k]);
      end
      if (b_ctl.fresh) begin
         t0 = sum_type'(vs * 3'd5);
         t1 = t0;
         t2 = t0;
      end else begin
         t0 = cs_ff[0] + cs_ff[1] + cs_ff[2] + cs_ff[3] + vs;
         t1 = cs_ff[1] + cs_ff[2] + cs_ff[3] + sum_type'(vs * 2'd2);
         t2 = cs_ff[2] + cs_ff[3] + sum_type'(vs * 2'd3);
      end
      case (b_ctl.s_lo)
         2'd0: begin
            slot_in[0] = t0; slot_in[1] = t1; slot_in[2] = t2;
         end
         2'd1: begin
            slot_in[0] = t1; slot_in[1] = t2; slot_in[2] = t2;
         end
         default: begin
            slot_in[0] = t2; slot_in[1] = t2; slot_in[2] = t2;
         end
      endcase
      for (int i = 0; i < NSLOT; i++) begin
         prod[i] = slot_ff[i] * sum_type'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LROWS; i++) begin
            cs_ff[i] <= '0;
         end
      end else if (b_valid) begin
         if (b_ctl.fresh) begin
            for (int i = 0; i < LROWS; i++) begin
               cs_ff[i] <= vs;
            end
         end else begin
            for (int i = 0; i < LROWS-1; i++) begin
               cs_ff[i] <= cs_ff[i+1];
            end
            cs_ff[LROWS-1] <= vs;
         end
      end
      for (int i = 0; i < NSLOT; i++) begin
         slot_ff[i]  <= slot_in[i];
         means_ff[i] <= prod[i][RECIP_SHIFT +: 8];
      end
   end

   assign d_means = means_ff;

endmodule

// ===== hdl/bfr_outq.sv =====
// Result queue and output register; sends group results one per cycle unless stalled.
module bfr_outq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bfr_pkg::grp_type            push_grp,
   output logic [bfr_pkg::OQ_PTR_W:0]  count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bfr_pkg::rsp_type            rsp_data
);
   import bfr_pkg::*;

   grp_type               grp_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]   wr_ff, rd_ff;
   logic [OQ_PTR_W:0]     count_ff;
   logic [1:0]            idx_ff;
   logic                  valid_ff;
   rsp_type               out_ff;
   grp_type               head;
   logic                  load, is_last, pop;
   pix_type               px;

   always_comb begin
      head    = grp_ff[rd_ff];
      load    = (count_ff != '0) && (!valid_ff || !rsp_stall);
      is_last = (idx_ff == head.n - 2'd1);
      pop     = load && is_last;
      px      = head.means[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         grp_ff[wr_ff] <= push_grp;
      end
      if (load) begin
         out_ff.mean0     <= px[7:0];
         out_ff.mean1     <= px[15:8];
         out_ff.mean2     <= px[23:16];
         out_ff.run_last  <= is_last;
         out_ff.frame_end <= is_last && head.fe;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff  <= rd_ff + 1'b1;
            idx_ff <= '0;
         end else if (load) begin
            idx_ff <= idx_ff + 2'd1;
         end
         count_ff <= count_ff + (OQ_PTR_W+1)'(push) - (OQ_PTR_W+1)'(pop);
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign count     = count_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule
